// ----- design/msb_first_bit_reader_macros.svh -----
// Assertion macros for the msb_first_bit_reader checker.
// Relies on aclk and aresetn being visible where a macro is used.
`ifndef MSB_FIRST_BIT_READER_MACROS_SVH
`define MSB_FIRST_BIT_READER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MFBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mfbr check failed");

// Next-cycle implication, disabled while in reset.
`define MFBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mfbr check failed");

`endif

// ----- design/mfbr_pkg.sv -----
// Shared constants, codes and word types for the msb_first_bit_reader.
// No dependencies.
package mfbr_pkg;

    localparam int BUF_BYTES   = 256;
    localparam int BUF_AW      = $clog2(BUF_BYTES);
    localparam int CNT_W       = $clog2(BUF_BYTES + 1);
    localparam int POS_W       = CNT_W + 3;
    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int NUM_BITS_W  = 6;
    localparam int BITS_LEFT_W = 12;
    localparam int MAX_READ    = 32;
    localparam int WIN_W       = VALUE_W + BYTE_W;
    localparam int FETCH_W     = $clog2(WIN_W / BYTE_W + 1);

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [BYTE_W-1:0]     byte_value;
        logic [NUM_BITS_W-1:0] num_bits;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [1:0]             status;
        logic [BITS_LEFT_W-1:0] bits_left;
    } out_word_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [BUF_AW-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

endpackage

// ----- design/mfbr_store.sv -----
// Single-port byte store with registered read.
// Depends on mfbr_pkg.
module mfbr_store
    import mfbr_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          mem_req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [BUF_BYTES];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
        end else if (mem_req.re) begin
            rdata_reg <= mem[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mfbr_ctrl.sv -----
// Request sequencer: position/fill bookkeeping, byte fetch and bit alignment.
// Depends on mfbr_pkg; drives the port of mfbr_store.
module mfbr_ctrl
    import mfbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_word,
    output mem_req_t          mem_req,
    input  logic [BYTE_W-1:0] rdata,
    output logic              res_valid,
    output out_word_t         res_word,
    input  logic              res_take
);

    typedef enum logic [1:0] {IDLE, FETCH, RESULT} state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [POS_W-1:0]       pos_reg, pos_next;       // {byte pos, bit pos}
    logic [BUF_AW-1:0]      addr_reg, addr_next;
    logic [FETCH_W-1:0]     issue_reg, issue_next;
    logic [FETCH_W-1:0]     recv_reg, recv_next;
    logic                   rvalid_reg, rvalid_next;
    logic [WIN_W-1:0]       acc_reg, acc_next;
    logic [2:0]             sh_reg, sh_next;
    logic [NUM_BITS_W-1:0]  n_reg, n_next;
    logic                   is_read_reg, is_read_next;
    logic [1:0]             status_reg, status_next;
    logic [BITS_LEFT_W-1:0] left_reg, left_next;

    logic [POS_W-1:0]        avail_cur;
    logic [NUM_BITS_W:0]     span;          // bit offset + count
    logic [NUM_BITS_W+1:0]   span_round;
    logic [WIN_W-1:0]        shifted;
    logic [VALUE_W-1:0]      mask;
    logic                    issue_now;

    function automatic logic [POS_W-1:0] avail_bits(input logic [CNT_W-1:0] fill,
                                                    input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] total;
        total = {fill, 3'b000};
        return (pos > total) ? '0 : total - pos;
    endfunction

    assign avail_cur  = avail_bits(fill_reg, pos_reg);
    assign span       = {1'b0, s_word.num_bits} + (NUM_BITS_W+1)'(pos_reg[2:0]);
    assign span_round = {1'b0, span} + (NUM_BITS_W+2)'(7);
    assign issue_now  = (state_reg == FETCH) && (issue_reg != '0);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        addr_next    = addr_reg;
        issue_next   = issue_reg;
        recv_next    = recv_reg;
        rvalid_next  = issue_now;
        acc_next     = acc_reg;
        sh_next      = sh_reg;
        n_next       = n_reg;
        is_read_next = is_read_reg;
        status_next  = status_reg;
        left_next    = left_reg;
        mem_req      = '0;
        mem_req.addr = addr_reg;

        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next   = RESULT;
                    status_next  = ST_OK;
                    is_read_next = 1'b0;
                    case (s_word.req_type)
                        REQ_APPEND: begin
                            if (fill_reg == CNT_W'(BUF_BYTES)) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.addr  = fill_reg[BUF_AW-1:0];
                                mem_req.wdata = s_word.byte_value;
                                fill_next     = fill_reg + CNT_W'(1);
                            end
                        end
                        REQ_READ: begin
                            if (s_word.num_bits > NUM_BITS_W'(MAX_READ)) begin
                                status_next = ST_COUNT;
                            end else if (POS_W'(s_word.num_bits) > avail_cur) begin
                                status_next = ST_SHORT;
                            end else if (s_word.num_bits != '0) begin
                                pos_next     = pos_reg + POS_W'(s_word.num_bits);
                                addr_next    = pos_reg[BUF_AW+2:3];
                                issue_next   = FETCH_W'(span_round >> 3);
                                recv_next    = FETCH_W'(span_round >> 3);
                                sh_next      = 3'd0 - span[2:0];
                                n_next       = s_word.num_bits;
                                is_read_next = 1'b1;
                                state_next   = FETCH;
                            end
                        end
                        REQ_CLEAR: begin
                            fill_next = '0;
                            pos_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                    left_next = BITS_LEFT_W'(avail_bits(fill_next, pos_next));
                end
            end
            FETCH: begin
                if (issue_now) begin
                    mem_req.re = 1'b1;
                    addr_next  = addr_reg + BUF_AW'(1);
                    issue_next = issue_reg - FETCH_W'(1);
                end
                if (rvalid_reg) begin
                    acc_next  = {acc_reg[WIN_W-BYTE_W-1:0], rdata};
                    recv_next = recv_reg - FETCH_W'(1);
                    if (recv_reg == FETCH_W'(1)) begin
                        state_next = RESULT;
                    end
                end
            end
            RESULT: begin
                if (res_take) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            fill_reg   <= '0;
            pos_reg    <= '0;
            issue_reg  <= '0;
            recv_reg   <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            addr_reg    <= addr_next;
            issue_reg   <= issue_next;
            recv_reg    <= recv_next;
            rvalid_reg  <= rvalid_next;
            acc_reg     <= acc_next;
            sh_reg      <= sh_next;
            n_reg       <= n_next;
            is_read_reg <= is_read_next;
            status_reg  <= status_next;
            left_reg    <= left_next;
        end
    end

    // last fetched byte sits in the low bits; drop the trailing bits, keep n
    assign shifted = acc_reg >> sh_reg;
    assign mask    = {VALUE_W{1'b1}} >> (NUM_BITS_W'(VALUE_W) - n_reg);

    assign s_ready             = (state_reg == IDLE);
    assign res_valid           = (state_reg == RESULT);
    assign res_word.value      = is_read_reg ? (shifted[VALUE_W-1:0] & mask) : '0;
    assign res_word.status     = status_reg;
    assign res_word.bits_left  = left_reg;

endmodule

// ----- design/msb_first_bit_reader.sv -----
// Top level of the MSB-first bitstream reader: byte store, sequencer, output register.
// Depends on mfbr_pkg, mfbr_store, mfbr_ctrl.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+----------------------------------
//   s_      | in  | s_valid / s_ready  | in_word_t  (req_type, byte, count)
//   m_      | out | m_valid / m_ready  | out_word_t (value, status, left)
//
// Fetches: append, clear, unused codes, error reads and zero-bit reads fetch no
// bytes; a read of n bits at bit offset b fetches ceil((b+n)/8) bytes, one byte
// a cycle from the single-port store.
// Reset: synchronous, active low; empties the buffer and zeroes the position.
// Byte store contents are not cleared; only bytes below the fill count are read.
// Stalls: one result may wait in the output register while the next word is
// taken; a second finished result holds the sequencer until m_ready.
module msb_first_bit_reader
    import mfbr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] rdata;
    logic              res_valid;
    out_word_t         res_word;
    logic              res_take;

    logic              m_valid_reg;
    out_word_t         m_word_reg;

    mfbr_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    mfbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .mem_req   (mem_req),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_word  (res_word),
        .res_take  (res_take)
    );

    // output register loads whenever it is empty or being drained
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_take) begin
                m_valid_reg <= 1'b1;
                m_word_reg  <= res_word;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ----- design/mfbr_checker.sv -----
// Port-level checker for msb_first_bit_reader, bound to the top level.
// Depends on mfbr_pkg and msb_first_bit_reader_macros.svh.
`include "msb_first_bit_reader_macros.svh"

module mfbr_checker
    import mfbr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_word,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] open_reg;   // words taken but not yet delivered

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + 2'(s_acc) - 2'(m_acc);
        end
    end

    `MFBR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word))
    `MFBR_ASSERT_NEXT(a_one_in_work, s_acc, !s_ready)
    `MFBR_ASSERT_NOW(a_no_orphan_result, m_valid, open_reg != 2'd0)
    `MFBR_ASSERT_NOW(a_open_bound, 1'b1, open_reg != 2'd3)
    `MFBR_ASSERT_NOW(a_error_zero, m_valid && m_word.status != ST_OK, m_word.value == '0)

endmodule

bind msb_first_bit_reader mfbr_checker u_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for msb_first_bit_reader: directed table, then random request mix.
// Depends on mfbr_pkg and the msb_first_bit_reader RTL; expected words come from a predictor or hand-written rows.
// Both handshakes idle at random; every result word is checked field by field in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfbr_pkg::*;

    // req_type 3 is not a real request; the block answers OK and changes nothing
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int N_RANDOM = 670;      // directed table adds about 280 more
    localparam int PLAN_ROWS = 26;
    localparam int DRAIN_CYCLES = 20;   // plenty of slack after the last result

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    msb_first_bit_reader uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #(8_000_000);
        $display("msb_first_bit_reader test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the reader: byte buffer, fill count, absolute bit position
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] shadow_bytes [BUF_BYTES];
    int                shadow_fill;
    int                shadow_pos;      // byte_pos*8 + bit_pos, never past fill*8

    out_word_t pending_results [$];
    int        errors;

    function automatic int bits_avail();
        return shadow_fill * 8 - shadow_pos;
    endfunction

    // Apply one accepted request to the shadow state and return its result word
    function automatic out_word_t reader_result(input in_word_t w);
        out_word_t        r;
        logic [VALUE_W-1:0] acc;
        r = '0;
        case (w.req_type)
            REQ_APPEND: begin
                if (shadow_fill >= BUF_BYTES) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_bytes[shadow_fill] = w.byte_value;
                    shadow_fill++;
                end
            end
            REQ_READ: begin
                // count check wins over the shortage check
                if (int'(w.num_bits) > MAX_READ) begin
                    r.status = ST_COUNT;
                end else if (int'(w.num_bits) > bits_avail()) begin
                    r.status = ST_SHORT;
                end else begin
                    acc = '0;
                    for (int i = 0; i < int'(w.num_bits); i++) begin
                        acc = {acc[VALUE_W-2:0],
                               shadow_bytes[shadow_pos >> 3][7 - (shadow_pos & 7)]};
                        shadow_pos++;
                    end
                    r.value = acc;
                end
            end
            REQ_CLEAR: begin
                shadow_fill = 0;
                shadow_pos  = 0;
            end
            default: ;
        endcase
        r.bits_left = BITS_LEFT_W'(bits_avail());
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, some long, plus calm stretches
    // ------------------------------------------------------------------
    int send_calm;
    int recv_calm;

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Result side backpressure: m_ready drops for random stretches
    initial begin
        int n;
        recv_calm = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            n = idle_len(recv_calm);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker. Everything changes just after posedge, so the word
    // seen at negedge with valid and ready high is the one taken next edge.
    // ------------------------------------------------------------------
    out_word_t want;

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing pending: value %h status %0d left %0d",
                         $time, m_word.value, m_word.status, m_word.bits_left);
            end else begin
                want = pending_results.pop_front();
                if (m_word.value !== want.value) begin
                    errors++;
                    $display("%0t: value mismatch: expected %h actual %h",
                             $time, want.value, m_word.value);
                end
                if (m_word.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_word.status);
                end
                if (m_word.bits_left !== want.bits_left) begin
                    errors++;
                    $display("%0t: bits_left mismatch: expected %0d actual %0d",
                             $time, want.bits_left, m_word.bits_left);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Called at a posedge; returns at the edge that took
    // the word. The shadow is updated right there, well before the result.
    // ------------------------------------------------------------------
    task automatic push_word(input in_word_t w, input bit typed, input out_word_t typed_want);
        int        gap;
        bit        took;
        out_word_t predicted;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        predicted = reader_result(w);
        // hand-written rows override the predictor, which still tracks state
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    int random_words;

    task automatic send_word(input logic [1:0] req, input int n);
        in_word_t w;
        w.req_type   = req;
        w.byte_value = BYTE_W'($urandom);
        w.num_bits   = NUM_BITS_W'(n);
        push_word(w, 1'b0, '0);
        if (req != REQ_UNUSED) random_words++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: special cases and field extremes
    // ------------------------------------------------------------------
    typedef struct {
        in_word_t  w;
        int        reps;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    plan_row_t dir_plan [PLAN_ROWS] = '{
        // empty buffer: zero-bit read, short read, count over 32 beats short
        '{'{REQ_READ,   8'h00,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_READ,   8'h00,  6'd1}, 1, 1'b1, '{32'h0, ST_SHORT, 12'd0}},
        '{'{REQ_READ,   8'hFF, 6'd63}, 1, 1'b1, '{32'h0, ST_COUNT, 12'd0}},
        '{'{REQ_READ,   8'h00, 6'd33}, 1, 1'b1, '{32'h0, ST_COUNT, 12'd0}},
        '{'{REQ_UNUSED, 8'hFF, 6'd63}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        // five bytes, then aligned full-width read and the tail
        '{'{REQ_APPEND, 8'hFF,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd8}},
        '{'{REQ_APPEND, 8'h00, 6'd63}, 1, 1'b1, '{32'h0, ST_OK,    12'd16}},
        '{'{REQ_APPEND, 8'hA5,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd24}},
        '{'{REQ_APPEND, 8'h5A,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd32}},
        '{'{REQ_APPEND, 8'h80,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd40}},
        '{'{REQ_READ,   8'h00, 6'd32}, 1, 1'b1, '{32'hFF00_A55A, ST_OK, 12'd8}},
        '{'{REQ_READ,   8'h00,  6'd9}, 1, 1'b1, '{32'h0, ST_SHORT, 12'd8}},
        '{'{REQ_READ,   8'h00,  6'd1}, 1, 1'b1, '{32'h1, ST_OK,    12'd7}},
        '{'{REQ_READ,   8'h00,  6'd7}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_READ,   8'hFF,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_CLEAR,  8'hFF, 6'd63}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        // unaligned reads across byte boundaries
        '{'{REQ_APPEND, 8'h6C,  6'd0}, 3, 1'b0, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_READ,   8'h00,  6'd3}, 1, 1'b0, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_READ,   8'h00, 6'd20}, 1, 1'b0, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_CLEAR,  8'h00,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}},
        // fill to the brim, one more append is refused
        '{'{REQ_APPEND, 8'h3C,  6'd0}, BUF_BYTES, 1'b0, '{32'h0, ST_OK, 12'd0}},
        '{'{REQ_APPEND, 8'h00,  6'd0}, 1, 1'b1, '{32'h0, ST_FULL,  12'd2048}},
        '{'{REQ_READ,   8'h00, 6'd32}, 1, 1'b1, '{32'h3C3C_3C3C, ST_OK, 12'd2016}},
        // 32 bits at offset 5 touch five bytes
        '{'{REQ_READ,   8'h00,  6'd5}, 1, 1'b0, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_READ,   8'h00, 6'd32}, 1, 1'b0, '{32'h0, ST_OK,    12'd0}},
        '{'{REQ_CLEAR,  8'h00,  6'd0}, 1, 1'b1, '{32'h0, ST_OK,    12'd0}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int k;
        int fills;
        int room;
        errors       = 0;
        random_words = 0;
        send_calm    = 0;
        shadow_fill  = 0;
        shadow_pos   = 0;
        fills        = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            repeat (dir_plan[i].reps)
                push_word(dir_plan[i].w, dir_plan[i].typed, dir_plan[i].want);
        end

        // Random part, mostly append-then-drain bursts so reads hit real data
        while (random_words < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                k = $urandom_range(1, 10);
                repeat (k) send_word(REQ_APPEND, $urandom_range(0, 63));
                while (bits_avail() > 0 && $urandom_range(0, 5) != 0) begin
                    room = (bits_avail() < MAX_READ) ? bits_avail() : MAX_READ;
                    send_word(REQ_READ, $urandom_range(0, room));
                end
            end else if (pick < 75) begin
                // noise: any code, any fields
                send_word(2'($urandom_range(0, 3)), $urandom_range(0, 63));
            end else if (pick < 85) begin
                // broken reads: oversize count or more than what is left
                if ($urandom_range(0, 1) == 0 || bits_avail() >= MAX_READ)
                    send_word(REQ_READ, $urandom_range(MAX_READ + 1, 63));
                else
                    send_word(REQ_READ, $urandom_range(bits_avail() + 1, MAX_READ));
            end else if (pick < 93) begin
                send_word(REQ_CLEAR, $urandom_range(0, 63));
            end else if (pick < 95 && fills < 2) begin
                fills++;
                while (shadow_fill < BUF_BYTES) send_word(REQ_APPEND, $urandom_range(0, 63));
                send_word(REQ_APPEND, $urandom_range(0, 63));
            end else begin
                // deeper buffer without draining
                k = $urandom_range(1, 30);
                repeat (k) send_word(REQ_APPEND, $urandom_range(0, 63));
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("msb_first_bit_reader test passed");
        end else begin
            $display("msb_first_bit_reader test failed");
        end
        $finish;
    end

endmodule
